@@ src/gbn_pkg.sv @@
// Package for the Go-Back-N endpoint: widths, codes and request types.
// No dependencies.
`timescale 1ns / 1ps
package gbn_pkg;

    localparam int SEQ_W            = 16;
    localparam int CHK_W            = 32;
    localparam int WINDOW_SIZE_DEF  = 8;
    localparam int SEQ_BITS_DEF     = 16;

    localparam logic [SEQ_W-1:0] NO_ACK = 16'hFFFF;

    // input modes
    localparam logic [1:0] MODE_MSG   = 2'd0;
    localparam logic [1:0] MODE_PKT   = 2'd1;
    localparam logic [1:0] MODE_TMO   = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_SEND  = 2'd0;
    localparam logic [1:0] KIND_DELIV = 2'd1;
    localparam logic [1:0] KIND_TIMER = 2'd2;

    typedef struct packed {
        logic [1:0]        mode;
        logic [SEQ_W-1:0]  seq_field;
        logic [SEQ_W-1:0]  ack_field;
        logic signed [CHK_W-1:0] check_field;
        logic [63:0]       payload_low;
        logic [63:0]       payload_mid;
        logic [31:0]       payload_high;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        kind;
        logic [SEQ_W-1:0]  out_seq;
        logic [SEQ_W-1:0]  out_ack;
        logic signed [CHK_W-1:0] out_check;
        logic [63:0]       out_payload_low;
        logic [63:0]       out_payload_mid;
        logic [31:0]       out_payload_high;
        logic              timer_start;
        logic              timer_stop;
        logic              last;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic sum;
        logic calc;
        logic send_new;
        logic take_ack;
        logic deliver;
        logic reack;
        logic tmr_only;
        logic iter_init;
        logic rd;
        logic resend;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic [1:0] mode;
        logic       full;
        logic       out_zero;
        logic       chk_ok;
        logic       ack_ok;
        logic       seq_ok;
        logic       rx_any;
        logic       iter_last;
        logic       out_free;
    } t_dp_stat;

endpackage

@@ src/gbn_ifs.sv @@
// Valid/ready channel interfaces for the endpoint's input and result streams.
// Depends on gbn_pkg.
`timescale 1ns / 1ps
interface gbn_in_if;
    logic              valid;
    logic              ready;
    gbn_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gbn_out_if;
    logic               valid;
    logic               ready;
    gbn_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ src/gbn_ctrl.sv @@
// Sequencing state machine of the endpoint; issues datapath commands.
// Depends on gbn_pkg.
`timescale 1ns / 1ps
module gbn_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  gbn_pkg::t_dp_stat i_stat,
    output gbn_pkg::t_dp_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SUM  = 3'd1;
    localparam logic [2:0] S_CALC = 3'd2;
    localparam logic [2:0] S_ACT  = 3'd3;
    localparam logic [2:0] S_READ = 3'd4;
    localparam logic [2:0] S_RES  = 3'd5;

    logic [2:0] r_state, n_state;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state = S_CALC;
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state = S_ACT;
            end
            S_ACT: begin
                case (i_stat.mode)
                    gbn_pkg::MODE_MSG: begin
                        if (i_stat.full) begin
                            n_state = S_IDLE;
                        end else if (i_stat.out_free) begin
                            o_cmd.send_new = 1'b1;
                            n_state = S_IDLE;
                        end
                    end
                    gbn_pkg::MODE_PKT: begin
                        if (!i_stat.chk_ok) begin
                            n_state = S_IDLE;
                        end else if (i_stat.ack_ok) begin
                            if (i_stat.out_free) begin
                                o_cmd.take_ack = 1'b1;
                                n_state = S_IDLE;
                            end
                        end else if (i_stat.seq_ok) begin
                            if (i_stat.out_free) begin
                                o_cmd.deliver = 1'b1;
                                n_state = S_IDLE;
                            end
                        end else if (i_stat.rx_any) begin
                            if (i_stat.out_free) begin
                                o_cmd.reack = 1'b1;
                                n_state = S_IDLE;
                            end
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                    gbn_pkg::MODE_TMO: begin
                        if (i_stat.out_zero) begin
                            if (i_stat.out_free) begin
                                o_cmd.tmr_only = 1'b1;
                                n_state = S_IDLE;
                            end
                        end else begin
                            o_cmd.iter_init = 1'b1;
                            n_state = S_READ;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state = S_RES;
            end
            S_RES: begin
                if (i_stat.out_free) begin
                    o_cmd.resend = 1'b1;
                    n_state = i_stat.iter_last ? S_IDLE : S_READ;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

@@ src/gbn_dp.sv @@
// Datapath of the endpoint: window counters, checksum, send buffer, result register.
// Depends on gbn_pkg.
`timescale 1ns / 1ps
module gbn_dp #(
    parameter int WINDOW_SIZE = gbn_pkg::WINDOW_SIZE_DEF,
    parameter int SEQ_BITS    = gbn_pkg::SEQ_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gbn_pkg::t_in_item  i_in,
    input  gbn_pkg::t_dp_cmd   i_cmd,
    output gbn_pkg::t_dp_stat  o_stat,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output gbn_pkg::t_out_item o_out
);

    localparam int SW    = gbn_pkg::SEQ_W;
    localparam int SLOT_W = $clog2(WINDOW_SIZE);
    localparam int CNT_W  = $clog2(WINDOW_SIZE + 1);
    localparam logic [SW-1:0] SEQ_MASK =
        (SEQ_BITS >= 16) ? 16'hFFFF : SW'((32'd1 << SEQ_BITS) - 32'd1);
    localparam logic [SLOT_W:0]   W_EXT  = (SLOT_W+1)'(WINDOW_SIZE);
    localparam logic [SLOT_W-1:0] W_LAST = SLOT_W'(WINDOW_SIZE - 1);
    localparam int ENT_W = SW + 32 + 160;

    typedef logic [ENT_W-1:0] t_entry;

    // sum of five payload bytes taken as signed
    function automatic logic signed [10:0] sum5(input logic [39:0] w);
        logic signed [10:0] s;
        s = '0;
        for (int i = 0; i < 5; i++) begin
            s = s + 11'(signed'(w[8*i +: 8]));
        end
        return s;
    endfunction

    gbn_pkg::t_in_item r_in;
    logic [SW-1:0]     r_base, r_next, r_exp, r_pend_ack;
    logic              r_rx_any, r_pend_v;
    logic [SLOT_W-1:0] r_base_slot, r_next_slot, r_iter_slot;
    logic [SW-1:0]     r_iter_seq;
    logic [CNT_W-1:0]  r_iter_cnt;
    logic signed [10:0] r_ps [4];
    logic [31:0]       r_csum;
    t_entry            r_mem [WINDOW_SIZE];
    t_entry            r_rd;
    logic              r_out_v;
    gbn_pkg::t_out_item r_out;

    logic [159:0]      w_pay;
    logic [SW-1:0]     w_outst, w_a, w_ack_off, w_new_base, w_la;
    logic [SW:0]       w_base_sum;
    logic [SLOT_W:0]   w_k, w_slot_sum;
    logic [SLOT_W-1:0] w_new_slot;
    logic [31:0]       w_csum;
    logic              w_free;

    assign w_pay   = {r_in.payload_high, r_in.payload_mid, r_in.payload_low};
    assign w_outst = (r_next - r_base) & SEQ_MASK;
    assign w_a     = r_pend_v ? r_pend_ack : gbn_pkg::NO_ACK;
    assign w_free  = !r_out_v || i_out_ready;
    assign w_la    = (r_exp - SW'(1)) & SEQ_MASK;

    // cumulative ack: new base and its slot (k is at most the window size)
    assign w_ack_off  = (r_in.ack_field - r_base) & SEQ_MASK;
    assign w_k        = (SLOT_W+1)'(w_ack_off) + (SLOT_W+1)'(1);
    assign w_base_sum = {1'b0, r_base} + (SW+1)'(w_k);
    assign w_new_base = w_base_sum[SW-1:0] & SEQ_MASK;
    assign w_slot_sum = {1'b0, r_base_slot} + w_k;
    always_comb begin
        if (w_base_sum > {1'b0, SEQ_MASK}) begin
            w_new_slot = w_new_base[SLOT_W-1:0];
        end else if (w_slot_sum >= W_EXT) begin
            w_new_slot = SLOT_W'(w_slot_sum - W_EXT);
        end else begin
            w_new_slot = w_slot_sum[SLOT_W-1:0];
        end
    end

    // checksum from the partial byte sums
    always_comb begin
        if (r_in.mode == gbn_pkg::MODE_MSG) begin
            w_csum = 32'(r_next) + 32'(w_a);
        end else begin
            w_csum = 32'(r_in.seq_field) + 32'(r_in.ack_field);
        end
        for (int i = 0; i < 4; i++) begin
            w_csum = w_csum + 32'(r_ps[i]);
        end
    end

    // status
    always_comb begin
        o_stat.mode      = r_in.mode;
        o_stat.full      = (w_outst >= SW'(WINDOW_SIZE));
        o_stat.out_zero  = (w_outst == '0);
        o_stat.chk_ok    = (r_csum == r_in.check_field);
        o_stat.ack_ok    = (r_in.ack_field != gbn_pkg::NO_ACK)
                           && (r_in.ack_field <= SEQ_MASK) && (w_ack_off < w_outst);
        o_stat.seq_ok    = (r_in.seq_field == r_exp);
        o_stat.rx_any    = r_rx_any;
        o_stat.iter_last = (SW'(r_iter_cnt) + SW'(1) == w_outst);
        o_stat.out_free  = w_free;
    end

    // input capture and checksum stages
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in <= i_in;
        end
        if (i_cmd.sum) begin
            for (int i = 0; i < 4; i++) begin
                r_ps[i] <= sum5(w_pay[40*i +: 40]);
            end
        end
        if (i_cmd.calc) begin
            r_csum <= w_csum;
        end
    end

    // send buffer, write on a new send, registered read on resend
    always_ff @(posedge i_clk) begin
        if (i_cmd.send_new) begin
            r_mem[r_next_slot] <= {w_a, r_csum, w_pay};
        end
        if (i_cmd.rd) begin
            r_rd <= r_mem[r_iter_slot];
        end
    end

    // window and receiver state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= '0;
            r_next      <= '0;
            r_exp       <= '0;
            r_pend_ack  <= '0;
            r_pend_v    <= 1'b0;
            r_rx_any    <= 1'b0;
            r_base_slot <= '0;
            r_next_slot <= '0;
            r_iter_seq  <= '0;
            r_iter_slot <= '0;
            r_iter_cnt  <= '0;
        end else begin
            if (i_cmd.send_new) begin
                r_next   <= (r_next + SW'(1)) & SEQ_MASK;
                r_pend_v <= 1'b0;
                if (r_next == SEQ_MASK || r_next_slot == W_LAST) begin
                    r_next_slot <= '0;
                end else begin
                    r_next_slot <= r_next_slot + SLOT_W'(1);
                end
            end
            if (i_cmd.take_ack) begin
                r_base      <= w_new_base;
                r_base_slot <= w_new_slot;
            end
            if (i_cmd.deliver) begin
                r_pend_ack <= r_exp;
                r_pend_v   <= 1'b1;
                r_exp      <= (r_exp + SW'(1)) & SEQ_MASK;
                r_rx_any   <= 1'b1;
            end
            if (i_cmd.iter_init) begin
                r_iter_seq  <= r_base;
                r_iter_slot <= r_base_slot;
                r_iter_cnt  <= '0;
            end
            if (i_cmd.resend) begin
                r_iter_seq <= (r_iter_seq + SW'(1)) & SEQ_MASK;
                r_iter_cnt <= r_iter_cnt + CNT_W'(1);
                if (r_iter_seq == SEQ_MASK || r_iter_slot == W_LAST) begin
                    r_iter_slot <= '0;
                end else begin
                    r_iter_slot <= r_iter_slot + SLOT_W'(1);
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_cmd.send_new || i_cmd.take_ack || i_cmd.deliver
                     || i_cmd.reack || i_cmd.tmr_only || i_cmd.resend) begin
            r_out_v <= 1'b1;
        end else if (i_out_ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.send_new) begin
            r_out <= '{gbn_pkg::KIND_SEND, r_next, w_a, r_csum, r_in.payload_low,
                       r_in.payload_mid, r_in.payload_high, (w_outst == '0), 1'b0, 1'b1};
        end else if (i_cmd.take_ack) begin
            r_out <= '{gbn_pkg::KIND_TIMER, '0, '0, '0, '0, '0, '0,
                       (w_new_base != r_next), 1'b1, 1'b1};
        end else if (i_cmd.deliver) begin
            r_out <= '{gbn_pkg::KIND_DELIV, '0, '0, '0, r_in.payload_low,
                       r_in.payload_mid, r_in.payload_high, 1'b0, 1'b0, 1'b1};
        end else if (i_cmd.reack) begin
            r_out <= '{gbn_pkg::KIND_SEND, '0, w_la, 32'(w_la), '0, '0, '0,
                       1'b0, 1'b0, 1'b1};
        end else if (i_cmd.tmr_only) begin
            r_out <= '{gbn_pkg::KIND_TIMER, '0, '0, '0, '0, '0, '0, 1'b1, 1'b0, 1'b1};
        end else if (i_cmd.resend) begin
            r_out <= '{gbn_pkg::KIND_SEND, r_iter_seq, r_rd[ENT_W-1 -: SW],
                       r_rd[191:160], r_rd[63:0], r_rd[127:64], r_rd[159:128],
                       (r_iter_cnt == '0), 1'b0, o_stat.iter_last};
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out       = r_out;

endmodule

@@ src/go_back_n_endpoint.sv @@
// Go-Back-N endpoint: send window with retransmit buffer and in-order receiver.
// An accepted request passes the checksum states SUM and CALC; state ACT then loads the
// result register. A timeout resends each buffered packet: a registered buffer read, then
// a result load. Both wait while a result is untaken; a new request is taken only in idle.
// Reset: synchronous active low, clears window counters and the result valid flag.
// Depends on gbn_pkg, gbn_ifs, gbn_ctrl, gbn_dp.
`timescale 1ns / 1ps
module go_back_n_endpoint #(
    parameter int WINDOW_SIZE = gbn_pkg::WINDOW_SIZE_DEF,
    parameter int SEQ_BITS    = gbn_pkg::SEQ_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gbn_in_if.sink     i_in,
    gbn_out_if.source  o_out
);

    gbn_pkg::t_dp_cmd  w_cmd;
    gbn_pkg::t_dp_stat w_stat;
    logic              w_in_ready;

    gbn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    gbn_dp #(
        .WINDOW_SIZE (WINDOW_SIZE),
        .SEQ_BITS    (SEQ_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in.data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_out       (o_out.data)
    );

    assign i_in.ready = w_in_ready;

endmodule

@@ tb/sv/tb_go_back_n_endpoint.sv @@
// Testbench for the Go-Back-N endpoint: random and directed requests, scoreboard check.
// Depends on gbn_pkg, gbn_ifs and the go_back_n_endpoint RTL.
`timescale 1ns / 1ps
module tb_go_back_n_endpoint;

    localparam int WIN = gbn_pkg::WINDOW_SIZE_DEF;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    gbn_in_if  in_ch ();
    gbn_out_if out_ch ();

    go_back_n_endpoint DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always #2 i_clk = ~i_clk;

    // endpoint state mirror
    logic [15:0] win_base, nxt_seq, rx_expect, held_ack;
    logic        rx_seen, held_valid;
    logic [15:0] slot_ack [WIN];
    logic [31:0] slot_chk [WIN];
    logic [63:0] slot_lo [WIN];
    logic [63:0] slot_mid [WIN];
    logic [31:0] slot_hi [WIN];

    gbn_pkg::t_in_item  req_q [$];
    gbn_pkg::t_out_item expect_q [$];

    int idle_in_pct = 31;
    int idle_out_pct = 57;
    bit hold_off = 1'b0;
    int errors = 0;
    int n_results = 0;
    int n_reqs = 0;

    function automatic logic [31:0] byte_sum(logic [63:0] w, int cnt);
        logic [31:0] s;
        s = '0;
        for (int i = 0; i < cnt; i++) s += 32'(signed'(w[8*i +: 8]));
        return s;
    endfunction

    function automatic logic [31:0] frame_sum(logic [15:0] sq, logic [15:0] ak,
                                              logic [63:0] lo, logic [63:0] mi,
                                              logic [31:0] hi);
        return 32'(sq) + 32'(ak) + byte_sum(lo, 8) + byte_sum(mi, 8)
               + byte_sum({32'h0, hi}, 4);
    endfunction

    function automatic gbn_pkg::t_out_item mk(logic [1:0] k, logic [15:0] sq,
                                              logic [15:0] ak, logic [31:0] c,
                                              logic [63:0] lo, logic [63:0] mi,
                                              logic [31:0] hi, logic st, logic sp);
        gbn_pkg::t_out_item r;
        r = '{k, sq, ak, c, lo, mi, hi, st, sp, 1'b0};
        return r;
    endfunction

    // endpoint predictor: appends the results of one request
    task automatic predict_endpoint(gbn_pkg::t_in_item it);
        logic [15:0] outst, a, la, s;
        logic [31:0] c;
        int first;
        first = expect_q.size();
        outst = nxt_seq - win_base;
        case (it.mode)
            gbn_pkg::MODE_MSG: if (outst < WIN) begin
                a = held_valid ? held_ack : gbn_pkg::NO_ACK;
                c = frame_sum(nxt_seq, a, it.payload_low, it.payload_mid, it.payload_high);
                slot_ack[nxt_seq % WIN] = a;
                slot_chk[nxt_seq % WIN] = c;
                slot_lo[nxt_seq % WIN] = it.payload_low;
                slot_mid[nxt_seq % WIN] = it.payload_mid;
                slot_hi[nxt_seq % WIN] = it.payload_high;
                expect_q.push_back(mk(gbn_pkg::KIND_SEND, nxt_seq, a, c, it.payload_low,
                    it.payload_mid, it.payload_high, outst == 0, 1'b0));
                nxt_seq++;
                held_valid = 1'b0;
            end
            gbn_pkg::MODE_PKT: if (frame_sum(it.seq_field, it.ack_field, it.payload_low,
                    it.payload_mid, it.payload_high) == it.check_field) begin
                if (it.ack_field != gbn_pkg::NO_ACK
                    && 16'(it.ack_field - win_base) < outst) begin
                    win_base = it.ack_field + 16'd1;
                    expect_q.push_back(mk(gbn_pkg::KIND_TIMER, 0, 0, 0, 0, 0, 0,
                        win_base != nxt_seq, 1'b1));
                end else if (it.seq_field == rx_expect) begin
                    expect_q.push_back(mk(gbn_pkg::KIND_DELIV, 0, 0, 0, it.payload_low,
                        it.payload_mid, it.payload_high, 1'b0, 1'b0));
                    held_ack = rx_expect;
                    held_valid = 1'b1;
                    rx_expect++;
                    rx_seen = 1'b1;
                end else if (rx_seen) begin
                    la = rx_expect - 16'd1;
                    expect_q.push_back(mk(gbn_pkg::KIND_SEND, 0, la, 32'(la), 0, 0, 0, 0, 0));
                end
            end
            gbn_pkg::MODE_TMO: if (outst == 0) begin
                expect_q.push_back(mk(gbn_pkg::KIND_TIMER, 0, 0, 0, 0, 0, 0, 1'b1, 1'b0));
            end else begin
                for (int i = 0; i < outst; i++) begin
                    s = win_base + 16'(i);
                    expect_q.push_back(mk(gbn_pkg::KIND_SEND, s, slot_ack[s % WIN],
                        slot_chk[s % WIN], slot_lo[s % WIN], slot_mid[s % WIN],
                        slot_hi[s % WIN], i == 0, 1'b0));
                end
            end
            default: ;
        endcase
        if (expect_q.size() > first) expect_q[$].last = 1'b1;
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    // build a network packet with valid or broken checksum
    function automatic gbn_pkg::t_in_item net_pkt(logic [15:0] sq, logic [15:0] ak, bit good);
        gbn_pkg::t_in_item it;
        it.mode = gbn_pkg::MODE_PKT;
        it.seq_field = sq;
        it.ack_field = ak;
        it.payload_low = rnd64();
        it.payload_mid = rnd64();
        it.payload_high = $urandom;
        it.check_field = frame_sum(sq, ak, it.payload_low, it.payload_mid, it.payload_high);
        if (!good) it.check_field ^= 32'(1) << $urandom_range(31);
        return it;
    endfunction

    function automatic gbn_pkg::t_in_item msg_req(logic [63:0] lo, logic [63:0] mi,
                                                  logic [31:0] hi);
        gbn_pkg::t_in_item it;
        it = '0;
        it.mode = gbn_pkg::MODE_MSG;
        it.payload_low = lo;
        it.payload_mid = mi;
        it.payload_high = hi;
        return it;
    endfunction

    function automatic gbn_pkg::t_in_item tmo_req();
        gbn_pkg::t_in_item it;
        it = '0;
        it.mode = gbn_pkg::MODE_TMO;
        return it;
    endfunction

    // driver: one request at a time from req_q
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (in_ch.valid && !in_ch.ready) begin
            // hold current request
        end else if (req_q.size() > 0 && !hold_off && $urandom_range(99) >= idle_in_pct) begin
            in_ch.data  <= req_q.pop_front();
            in_ch.valid <= 1'b1;
        end else begin
            in_ch.valid <= 1'b0;
        end
    end

    // predict on acceptance
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            predict_endpoint(in_ch.data);
            n_reqs++;
        end
    end

    // monitor: result ready and comparison
    always @(posedge i_clk) begin
        gbn_pkg::t_out_item e, g;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                g = out_ch.data;
                n_results++;
                if (expect_q.size() == 0) begin
                    $display("%0t unexpected result: expected none actual %p", $time, g);
                    errors++;
                end else begin
                    e = expect_q.pop_front();
                    if (g !== e) begin
                        $display("%0t mismatch: expected %p actual %p", $time, e, g);
                        errors++;
                    end
                end
            end
            out_ch.ready <= ($urandom_range(99) >= idle_out_pct);
        end
    end

    // wait until the queue and the scoreboard are drained
    task automatic drain();
        while (req_q.size() > 0 || in_ch.valid) @(posedge i_clk);
        while (expect_q.size() > 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    // random phase: mostly well-formed traffic with acks in the window
    task automatic random_traffic(int count);
        int r;
        logic [15:0] sq, ak;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (r < 35) begin
                req_q.push_back(msg_req(rnd64(), rnd64(), $urandom));
            end else if (r < 55) begin
                ak = ($urandom_range(3) == 0) ? gbn_pkg::NO_ACK
                     : win_base + 16'($urandom_range(WIN));
                req_q.push_back(net_pkt(16'($urandom), ak, 1'b1));
            end else if (r < 75) begin
                sq = ($urandom_range(3) == 0) ? 16'($urandom) : rx_expect;
                req_q.push_back(net_pkt(sq, gbn_pkg::NO_ACK, $urandom_range(9) != 0));
            end else if (r < 85) begin
                req_q.push_back(tmo_req());
            end else if (r < 90) begin
                req_q.push_back(net_pkt(16'($urandom), 16'($urandom), $urandom_range(1)));
            end else if (r < 93) begin
                gbn_pkg::t_in_item it;
                it = msg_req(rnd64(), rnd64(), $urandom);
                it.mode = 2'd3;
                req_q.push_back(it);
            end else begin
                req_q.push_back(msg_req(rnd64(), rnd64(), $urandom));
            end
            // the generator reads the predicted state, so keep the queue short
            while (req_q.size() > 0) @(posedge i_clk);
        end
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        win_base = 0; nxt_seq = 0; rx_expect = 0; held_ack = 0;
        rx_seen = 0; held_valid = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: idle timeout, out-of-order before any data, fill and overflow window
        req_q.push_back(tmo_req());
        req_q.push_back(net_pkt(16'd5, gbn_pkg::NO_ACK, 1'b1));
        req_q.push_back(msg_req('1, '1, '1));
        req_q.push_back(msg_req('0, '0, '0));
        req_q.push_back(msg_req({8{8'h80}}, {8{8'h7F}}, 32'h80808080));
        for (int i = 0; i < 7; i++) req_q.push_back(msg_req(rnd64(), rnd64(), $urandom));
        req_q.push_back(tmo_req());
        drain();
        // data in order, duplicate, bad checksum, out-of-range ack, then cumulative acks
        req_q.push_back(net_pkt(16'd0, gbn_pkg::NO_ACK, 1'b1));
        req_q.push_back(net_pkt(16'd0, gbn_pkg::NO_ACK, 1'b1));
        req_q.push_back(net_pkt(16'd1, gbn_pkg::NO_ACK, 1'b0));
        req_q.push_back(net_pkt(16'hFFFF, 16'd40, 1'b1));
        req_q.push_back(net_pkt(16'd1, 16'd3, 1'b1));
        req_q.push_back(net_pkt(16'd9, 16'd7, 1'b1));
        req_q.push_back(msg_req(rnd64(), rnd64(), $urandom));
        req_q.push_back(tmo_req());
        req_q.push_back(tmo_req());
        drain();

        random_traffic(120);
        drain();
        idle_in_pct = 57; idle_out_pct = 31;
        random_traffic(120);
        // hold the sender until every result is in
        hold_off = 1'b1;
        while (in_ch.valid || expect_q.size() > 0) @(posedge i_clk);
        hold_off = 1'b0;
        idle_in_pct = 0; idle_out_pct = 0;
        random_traffic(100);
        drain();

        $display("Covered %0d requests and %0d results: sends, deliveries, acks,", n_reqs,
                 n_results);
        $display("re-acks, bad checksums, full window, timeouts and the unused mode.");
        if (errors == 0) begin
            $display("go_back_n_endpoint verification clean");
        end else begin
            $display("go_back_n_endpoint verification failed");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("go_back_n_endpoint verification failed");
        $finish;
    end
endmodule
